@@ sv/assert_macros.svh @@
// Assertion macros used by the RTL of the sorted byte multiset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checks a property on every rising clock edge outside of reset.
`define SMB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define SMB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SMB_ASSERT(label, clk, rst_n, prop, msg)
`define SMB_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ sv/smb_pkg.sv @@
// Types and constants of the sorted byte multiset.
`default_nettype none

package smb_pkg;

  localparam int unsigned VALUE_W = 8;
  localparam int unsigned COUNT_W = 6;

  typedef enum logic [0:0] {
    ACTION_INSERT = 1'b0,
    ACTION_REMOVE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_e;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [COUNT_W-1:0] count_t;

endpackage

`default_nettype wire

@@ sv/smb_req_if.sv @@
// Request channel of the sorted byte multiset: an action and a byte value.
`default_nettype none

interface smb_req_if;
  logic             valid;
  logic             ready;
  smb_pkg::action_e action;
  smb_pkg::value_t  value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

`default_nettype wire

@@ sv/smb_rsp_if.sv @@
// Response channel of the sorted byte multiset: a status and the new count.
`default_nettype none

interface smb_rsp_if;
  logic             valid;
  logic             ready;
  smb_pkg::status_e status;
  smb_pkg::count_t  count;

  modport source (output valid, output status, output count, input ready);
  modport sink   (input valid, input status, input count, output ready);
endinterface

`default_nettype wire

@@ sv/sorted_byte_multiset.sv @@
// Sorted byte multiset: ordered store with iterative insert and remove.
// An insert moves each held value larger than the new one up by one, then writes the new
//   value in the hole; a remove walks every held value; a refusal goes straight to the result.
// Items are handled one at a time; each step is a memory read, then one compare and write.
// A new item is accepted while the previous result still waits in the output register.
// Reset clears the count and the control state at once; there is no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module sorted_byte_multiset #(
  parameter int unsigned CAPACITY = 32
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  smb_req_if.sink    req_i,
  smb_rsp_if.source  rsp_o
);

  // Index width covers the entries, count width covers the full count.
  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // The sequencer walks the store one entry at a time: a read state issues the
  // memory read, then a compare state compares the read value with the item's
  // value in the shared comparator and writes the moved entry back.
  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_INS_RD  = 7'b0000010,
    S_INS_CMP = 7'b0000100,
    S_INS_PUT = 7'b0001000,
    S_REM_RD  = 7'b0010000,
    S_REM_CMP = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Item being worked on.
  smb_pkg::action_e act_q, act_d;
  smb_pkg::value_t  val_q, val_d;

  // Walking index: the hole position on insert, the read position on remove.
  logic [IW-1:0] idx_q, idx_d;
  logic          found_q, found_d;
  smb_pkg::status_e res_q, res_d;

  logic [CW-1:0] held_q, held_d;

  // Output register.
  logic             rsp_valid_q, rsp_valid_d;
  smb_pkg::status_e rsp_status_q, rsp_status_d;
  smb_pkg::count_t  rsp_count_q, rsp_count_d;

  // Value store: one write port and one registered read port.
  smb_pkg::value_t mem [CAPACITY];
  smb_pkg::value_t rd_data_q;
  logic [IW-1:0]   rd_addr;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  smb_pkg::value_t wr_data;

  // Shared comparator on the read value and the item's value.
  logic cmp_gt;
  logic cmp_eq;

  logic req_fire;
  logic rsp_free;
  logic last_entry;

  assign cmp_gt = (rd_data_q > val_q);
  assign cmp_eq = (rd_data_q == val_q);

  assign req_i.ready  = (state_q == S_IDLE);
  assign req_fire     = req_i.valid && req_i.ready;
  assign rsp_free     = !rsp_valid_q || rsp_o.ready;
  assign last_entry   = (CW'(idx_q) == (held_q - CW'(1)));

  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.status = rsp_status_q;
  assign rsp_o.count  = rsp_count_q;

  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    val_d        = val_q;
    idx_d        = idx_q;
    found_d      = found_q;
    res_d        = res_q;
    held_d       = held_q;
    rsp_valid_d  = rsp_valid_q;
    rsp_status_d = rsp_status_q;
    rsp_count_d  = rsp_count_q;
    rd_addr      = idx_q;
    wr_en        = 1'b0;
    wr_addr      = idx_q;
    wr_data      = val_q;

    // The consumer takes the waiting result.
    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          act_d   = req_i.action;
          val_d   = req_i.value;
          found_d = 1'b0;
          idx_d   = '0;
          if (req_i.action == smb_pkg::ACTION_INSERT) begin
            if (held_q == CW'(CAPACITY)) begin
              res_d   = smb_pkg::STATUS_FULL;
              state_d = S_DONE;
            end else if (held_q == '0) begin
              state_d = S_INS_PUT;
            end else begin
              // The hole starts just above the last held value.
              idx_d   = IW'(held_q);
              state_d = S_INS_RD;
            end
          end else begin
            if (held_q == '0) begin
              res_d   = smb_pkg::STATUS_NOT_FOUND;
              state_d = S_DONE;
            end else begin
              state_d = S_REM_RD;
            end
          end
        end
      end

      S_INS_RD: begin
        rd_addr = idx_q - IW'(1);
        state_d = S_INS_CMP;
      end

      S_INS_CMP: begin
        // Values larger than the new one move up into the hole; an equal value
        // stays below, so the new copy lands after those already held.
        wr_en   = 1'b1;
        wr_addr = idx_q;
        if (cmp_gt) begin
          wr_data = rd_data_q;
          if (idx_q == IW'(1)) begin
            state_d = S_INS_PUT;
          end else begin
            state_d = S_INS_RD;
          end
          idx_d = idx_q - IW'(1);
        end else begin
          wr_data = val_q;
          res_d   = smb_pkg::STATUS_DONE;
          state_d = S_DONE;
        end
      end

      S_INS_PUT: begin
        // The store is empty or every held value was larger: the new one goes to the front.
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = val_q;
        res_d   = smb_pkg::STATUS_DONE;
        state_d = S_DONE;
      end

      S_REM_RD: begin
        rd_addr = idx_q;
        state_d = S_REM_CMP;
      end

      S_REM_CMP: begin
        // Once the first match is found, each later value moves down by one.
        if (found_q) begin
          wr_en   = 1'b1;
          wr_addr = idx_q - IW'(1);
          wr_data = rd_data_q;
        end
        if (last_entry) begin
          if (found_q || cmp_eq) begin
            res_d = smb_pkg::STATUS_DONE;
          end else begin
            res_d = smb_pkg::STATUS_NOT_FOUND;
          end
          state_d = S_DONE;
        end else begin
          found_d = found_q || cmp_eq;
          idx_d   = idx_q + IW'(1);
          state_d = S_REM_RD;
        end
      end

      S_DONE: begin
        // Wait here until the output register is free, then commit the count.
        if (rsp_free) begin
          if (res_q == smb_pkg::STATUS_DONE) begin
            if (act_q == smb_pkg::ACTION_INSERT) begin
              held_d = held_q + CW'(1);
            end else begin
              held_d = held_q - CW'(1);
            end
          end
          rsp_valid_d  = 1'b1;
          rsp_status_d = res_q;
          rsp_count_d  = smb_pkg::COUNT_W'(held_d);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    val_q        <= val_d;
    idx_q        <= idx_d;
    found_q      <= found_d;
    res_q        <= res_d;
    rsp_status_q <= rsp_status_d;
    rsp_count_q  <= rsp_count_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  `SMB_ASSERT(a_held_in_range, clk_i, rst_ni, held_q <= CW'(CAPACITY), "count above capacity")
  `SMB_ASSERT(a_held_changes_at_commit, clk_i, rst_ni, (held_q != $past(held_q)) |-> ($past(state_q) == S_DONE), "count changed outside commit")
  `SMB_ASSERT(a_accept_leaves_idle, clk_i, rst_ni, req_fire |=> (state_q != S_IDLE), "item accepted but sequencer stayed idle")
  `SMB_ASSERT(a_done_moves_count, clk_i, rst_ni, ((state_q == S_DONE) && rsp_free && (res_q == smb_pkg::STATUS_DONE)) |=> (held_q != $past(held_q)), "completed item left count unchanged")

endmodule

`default_nettype wire

@@ bench/smb_outcome_check.sv @@
`timescale 1ns / 100ps
// Monitor of both channels that tracks the multiset content and checks every result.
module smb_outcome_check #(
  parameter int unsigned CAPACITY = 32
) (
  input  wire clk_i,
  input  wire rst_ni,
  smb_req_if  req,
  smb_rsp_if  rsp,
  output int  errors_o,
  output int  waiting_o
);

  typedef struct packed {
    smb_pkg::status_e status;
    smb_pkg::count_t  count;
  } outcome_t;

  smb_pkg::value_t held_values [CAPACITY];
  int unsigned     held_n = 0;
  outcome_t        pending_outcomes [$];
  int              errors = 0;
  int              results_seen = 0;

  // Applies one action to the tracked content and returns the result it must give.
  function automatic outcome_t apply_item(smb_pkg::action_e act, smb_pkg::value_t val);
    outcome_t    res;
    int unsigned pos;
    pos = 0;
    res.status = smb_pkg::STATUS_DONE;
    if (act == smb_pkg::ACTION_INSERT) begin
      if (held_n >= CAPACITY) begin
        res.status = smb_pkg::STATUS_FULL;
      end else begin
        // Equal values already held stay in front of the new one.
        while (pos < held_n && held_values[pos] <= val) pos++;
        for (int unsigned k = held_n; k > pos; k--) held_values[k] = held_values[k - 1];
        held_values[pos] = val;
        held_n++;
      end
    end else begin
      while (pos < held_n && held_values[pos] != val) pos++;
      if (pos >= held_n) begin
        res.status = smb_pkg::STATUS_NOT_FOUND;
      end else begin
        for (int unsigned k = pos; k + 1 < held_n; k++) held_values[k] = held_values[k + 1];
        held_n--;
      end
    end
    res.count = smb_pkg::count_t'(held_n);
    return res;
  endfunction

  task automatic report(input string what);
    errors++;
    if (errors <= 10) $display("[%0t] result %0d: %s", $time, results_seen, what);
  endtask

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni) begin
      // Results are checked before the new item is recorded: none can belong to it.
      if (rsp.valid && rsp.ready) begin
        if (pending_outcomes.size() == 0) begin
          report($sformatf("unexpected result status %0d count %0d", rsp.status, rsp.count));
        end else begin
          want = pending_outcomes.pop_front();
          if (rsp.status !== want.status)
            report($sformatf("status expected %0d got %0d", want.status, rsp.status));
          if (rsp.count !== want.count)
            report($sformatf("count expected %0d got %0d", want.count, rsp.count));
        end
        results_seen++;
      end
      if (req.valid && req.ready) pending_outcomes.push_back(apply_item(req.action, req.value));
    end
    errors_o  <= errors;
    waiting_o <= pending_outcomes.size();
  end

endmodule

@@ bench/tb_sorted_byte_multiset.sv @@
`timescale 1ns / 100ps
// Top of the sorted byte multiset testbench: clock, reset, stimulus, pacing and verdict.
module tb_sorted_byte_multiset;

  localparam int unsigned CAPACITY        = 32;
  // Longest stretch without any item moving on either channel before the run is declared hung.
  localparam int unsigned STALL_LIMIT     = 5000;
  // Quiet cycles after the last expected result, to catch stray extra results.
  localparam int unsigned DRAIN_CYCLES    = 100;
  // Length of the long receiver hold-off that stalls the block.
  localparam int unsigned HOLDOFF_CYCLES  = 300;
  localparam int unsigned EPISODE_LEN     = 96;
  localparam int unsigned ITEMS_PER_PHASE = 370;

  logic clk_i;
  logic rst_ni = 1'b0;

  smb_req_if req ();
  smb_rsp_if rsp ();

  int errors;
  int waiting;

  // Pacing knobs, written only by the stimulus process.
  int unsigned send_idle_pct  = 0;
  int unsigned rsp_stall_pct  = 0;
  int unsigned holdoffs_asked = 0;

  sorted_byte_multiset #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  smb_outcome_check #(
    .CAPACITY(CAPACITY)
  ) outcome_check (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req      (req),
    .rsp      (rsp),
    .errors_o (errors),
    .waiting_o(waiting)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Offers one item, after a random number of idle cycles, and returns at the
  // edge where the block takes it. Valid stays high into the next item unless
  // that item starts with an idle cycle.
  task automatic offer(input smb_pkg::action_e act, input smb_pkg::value_t val);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid  <= 1'b1;
    req.action <= act;
    req.value  <= val;
    do @(posedge clk_i); while (!req.ready);
  endtask

  // Random traffic in episodes. Each episode draws a small pool of values so
  // that removes mostly find something and duplicates are common, and leans
  // toward inserts (filling past full), removes (draining past empty) or
  // neither. One item in ten takes a value from the whole byte range.
  task automatic run_episodes(input int unsigned n_items);
    smb_pkg::value_t  pool [8];
    int unsigned      insert_pct;
    int unsigned      sent;
    int unsigned      episode;
    smb_pkg::action_e act;
    smb_pkg::value_t  val;
    sent    = 0;
    episode = 0;
    while (sent < n_items) begin
      foreach (pool[i]) pool[i] = smb_pkg::value_t'($urandom_range(255));
      case (episode % 3)
        0: begin
          insert_pct = 80;
        end
        1: begin
          insert_pct = 20;
        end
        default: begin
          insert_pct = 50;
        end
      endcase
      for (int unsigned j = 0; j < EPISODE_LEN && sent < n_items; j++) begin
        act = ($urandom_range(99) < insert_pct) ? smb_pkg::ACTION_INSERT
                                                : smb_pkg::ACTION_REMOVE;
        val = ($urandom_range(9) == 0) ? smb_pkg::value_t'($urandom_range(255))
                                       : pool[$urandom_range(7)];
        offer(act, val);
        sent++;
      end
      episode++;
    end
  endtask

  // The receiver paces the result channel on its own. When the stimulus asks
  // for a hold-off, it keeps ready low for a long counted stretch while the
  // sender goes on offering items.
  initial begin : receiver
    int unsigned served;
    int unsigned quiet;
    served = 0;
    quiet  = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (quiet == 0 && served != holdoffs_asked) begin
        served = holdoffs_asked;
        quiet  = HOLDOFF_CYCLES;
      end
      if (quiet != 0) begin
        quiet--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  // Ends the run if neither channel moves an item for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    req.valid  <= 1'b0;
    req.action <= smb_pkg::ACTION_INSERT;
    req.value  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, without idling: a remove from the empty store, the
    // extreme values, duplicates kept and removed one copy at a time, a
    // remove of a value that is absent from a non-empty store, and the
    // alternating bit patterns.
    offer(smb_pkg::ACTION_REMOVE, 8'h00);
    offer(smb_pkg::ACTION_INSERT, 8'h80);
    offer(smb_pkg::ACTION_INSERT, 8'h00);
    offer(smb_pkg::ACTION_INSERT, 8'hFF);
    offer(smb_pkg::ACTION_INSERT, 8'h80);
    offer(smb_pkg::ACTION_INSERT, 8'h7F);
    offer(smb_pkg::ACTION_INSERT, 8'h01);
    offer(smb_pkg::ACTION_INSERT, 8'hFE);
    offer(smb_pkg::ACTION_INSERT, 8'hAA);
    offer(smb_pkg::ACTION_INSERT, 8'h55);
    offer(smb_pkg::ACTION_REMOVE, 8'h33);
    offer(smb_pkg::ACTION_REMOVE, 8'h80);
    offer(smb_pkg::ACTION_REMOVE, 8'h80);
    offer(smb_pkg::ACTION_REMOVE, 8'h80);
    offer(smb_pkg::ACTION_REMOVE, 8'hFF);
    offer(smb_pkg::ACTION_REMOVE, 8'h00);
    offer(smb_pkg::ACTION_REMOVE, 8'hAA);
    offer(smb_pkg::ACTION_REMOVE, 8'h55);
    offer(smb_pkg::ACTION_REMOVE, 8'h7F);
    offer(smb_pkg::ACTION_REMOVE, 8'h01);
    offer(smb_pkg::ACTION_REMOVE, 8'hFE);
    offer(smb_pkg::ACTION_REMOVE, 8'hFE);

    // No idling, with a long receiver hold-off in the middle so the block
    // stalls and stops accepting new items for a while.
    run_episodes(ITEMS_PER_PHASE / 2);
    holdoffs_asked++;
    run_episodes(ITEMS_PER_PHASE / 2);

    // Sender idles often.
    send_idle_pct = 45;
    rsp_stall_pct = 0;
    run_episodes(ITEMS_PER_PHASE);

    // Receiver stalls often, and holds off once more.
    send_idle_pct = 0;
    rsp_stall_pct = 45;
    run_episodes(ITEMS_PER_PHASE / 2);
    holdoffs_asked++;
    run_episodes(ITEMS_PER_PHASE / 2);

    // Both sides idle.
    send_idle_pct = 36;
    rsp_stall_pct = 36;
    run_episodes(ITEMS_PER_PHASE);

    req.valid <= 1'b0;
    // One edge first, so the count of waiting results includes the last item.
    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0 && waiting == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
